// ===== rtl/core/orl_pkg.sv =====
package orl_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned PairW  = 8;
  localparam int unsigned CodeW  = 4;

  localparam logic [CharW-1:0] ChNul    = 8'h00;
  localparam logic [CharW-1:0] ChDot    = 8'h2E;
  localparam logic [CharW-1:0] ChUnder  = 8'h5F;
  localparam logic [CharW-1:0] ChQuote  = 8'h22;
  localparam logic [CharW-1:0] ChBslash = 8'h5C;
  localparam logic [CharW-1:0] ChComma  = 8'h2C;
  localparam logic [CharW-1:0] ChEquals = 8'h3D;

  localparam logic [PairW-1:0] PairMax = {PairW{1'b1}};

  typedef enum logic [CodeW-1:0] {
    PH_CLASS_START = 4'd0,
    PH_CLASS_BODY  = 4'd1,
    PH_KEY_START   = 4'd2,
    PH_KEY_BODY    = 4'd3,
    PH_VALUE_START = 4'd4,
    PH_STRING      = 4'd5,
    PH_NUMBER      = 4'd6,
    PH_AFTER_VALUE = 4'd7,
    PH_ERROR       = 4'd8
  } phase_e;

  typedef enum logic [CodeW-1:0] {
    RL_CLASS   = 4'd0,
    RL_DOT     = 4'd1,
    RL_KEY     = 4'd2,
    RL_EQUALS  = 4'd3,
    RL_QUOTE   = 4'd4,
    RL_STRCHR  = 4'd5,
    RL_ESCAPE  = 4'd6,
    RL_DIGIT   = 4'd7,
    RL_COMMA   = 4'd8,
    RL_IGNORED = 4'd9
  } role_e;

  typedef enum logic [CodeW-1:0] {
    ER_NONE         = 4'd0,
    ER_BAD_CLASS    = 4'd1,
    ER_EXPECT_DOT   = 4'd2,
    ER_BAD_KEY      = 4'd3,
    ER_PREMATURE    = 4'd4,
    ER_EXPECT_EQ    = 4'd5,
    ER_BAD_STRING   = 4'd6,
    ER_ILLEGAL_VAL  = 4'd7,
    ER_EXPECT_COMMA = 4'd8
  } err_e;

  typedef struct packed {
    phase_e           phase;
    logic             esc;
    err_e             err;
    logic [PairW-1:0] pair_cnt;
  } state_t;

  typedef struct packed {
    role_e            role;
    err_e             err;
    logic             pair_done;
    logic [PairW-1:0] pair_index;
    logic             string_done;
  } result_t;

  localparam state_t StateReset = '{
    phase:    PH_CLASS_START,
    esc:      1'b0,
    err:      ER_NONE,
    pair_cnt: '0
  };

  function automatic logic is_alpha(input logic [CharW-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic ident_start(input logic [CharW-1:0] c);
    return is_alpha(c) || (c == ChUnder);
  endfunction

  function automatic logic ident_char(input logic [CharW-1:0] c);
    return is_alpha(c) || is_digit(c) || (c == ChUnder);
  endfunction

endpackage

// ===== rtl/core/orl_step.sv =====
module orl_step (
  input  orl_pkg::state_t            state_i,
  input  logic [orl_pkg::CharW-1:0]  char_i,
  output orl_pkg::state_t            state_o,
  output orl_pkg::result_t           result_o
);
  import orl_pkg::*;

  role_e  role;
  err_e   err;
  logic   done;
  logic   last;
  state_t nxt;

  always_comb begin
    nxt  = state_i;
    role = RL_IGNORED;
    err  = ER_NONE;
    done = 1'b0;
    last = (char_i == ChNul);

    case (state_i.phase)
      PH_CLASS_START: begin
        if (ident_start(char_i)) begin
          role      = RL_CLASS;
          nxt.phase = PH_CLASS_BODY;
        end else begin
          err = ER_BAD_CLASS;
        end
      end
      PH_CLASS_BODY: begin
        if (last) begin
          role = RL_IGNORED;
        end else if (ident_char(char_i)) begin
          role = RL_CLASS;
        end else if (char_i == ChDot) begin
          role      = RL_DOT;
          nxt.phase = PH_KEY_START;
        end else begin
          err = ER_EXPECT_DOT;
        end
      end
      PH_KEY_START: begin
        if (ident_start(char_i)) begin
          role      = RL_KEY;
          nxt.phase = PH_KEY_BODY;
        end else begin
          err = ER_BAD_KEY;
        end
      end
      PH_KEY_BODY: begin
        if (last) begin
          err = ER_PREMATURE;
        end else if (ident_char(char_i)) begin
          role = RL_KEY;
        end else if (char_i == ChEquals) begin
          role      = RL_EQUALS;
          nxt.phase = PH_VALUE_START;
        end else begin
          err = ER_EXPECT_EQ;
        end
      end
      PH_VALUE_START: begin
        if (char_i == ChQuote) begin
          role      = RL_QUOTE;
          nxt.phase = PH_STRING;
          nxt.esc   = 1'b0;
        end else if (is_digit(char_i)) begin
          role      = RL_DIGIT;
          nxt.phase = PH_NUMBER;
        end else begin
          err = ER_ILLEGAL_VAL;
        end
      end
      PH_STRING: begin
        if (last) begin
          err = ER_BAD_STRING;
        end else if (state_i.esc) begin
          role    = RL_STRCHR;
          nxt.esc = 1'b0;
        end else if (char_i == ChBslash) begin
          role    = RL_ESCAPE;
          nxt.esc = 1'b1;
        end else if (char_i == ChQuote) begin
          role      = RL_QUOTE;
          done      = 1'b1;
          nxt.phase = PH_AFTER_VALUE;
        end else begin
          role = RL_STRCHR;
        end
      end
      PH_NUMBER: begin
        if (last) begin
          done = 1'b1;
        end else if (is_digit(char_i)) begin
          role = RL_DIGIT;
        end else if (char_i == ChComma) begin
          role      = RL_COMMA;
          done      = 1'b1;
          nxt.phase = PH_KEY_START;
        end else begin
          err = ER_EXPECT_COMMA;
        end
      end
      PH_AFTER_VALUE: begin
        if (last) begin
          role = RL_IGNORED;
        end else if (char_i == ChComma) begin
          role      = RL_COMMA;
          nxt.phase = PH_KEY_START;
        end else begin
          err = ER_EXPECT_COMMA;
        end
      end
      default: begin
        role = RL_IGNORED;
      end
    endcase

    if (err != ER_NONE) begin
      role      = RL_IGNORED;
      nxt.phase = PH_ERROR;
      if (state_i.err == ER_NONE) begin
        nxt.err = err;
      end
    end
    if (done && (state_i.pair_cnt != PairMax)) begin
      nxt.pair_cnt = state_i.pair_cnt + 1'b1;
    end

    result_o.role        = role;
    result_o.err         = nxt.err;
    result_o.pair_done   = done;
    result_o.pair_index  = state_i.pair_cnt;
    result_o.string_done = last;

    state_o = last ? StateReset : nxt;
  end

endmodule

// ===== rtl/core/object_path_reference_lexer.sv =====
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+---------------------------------
// input    | in        | in_valid_i / in_stall_o    | char_in_i
// output   | out       | out_valid_o / out_stall_i  | role_o, error_code_o,
//          |           |                            | pair_done_o, pair_index_o,
//          |           |                            | string_done_o
//
// One byte is taken per cycle unless in_stall_o is high; results leave the result register.
// The parse state advances when a byte moves from the input register to the result register.
// Reset clears both registers' valid flags and returns the parser to the class name start.
// A stalled result holds both stages; in_stall_o rises only while both registers are full.
module object_path_reference_lexer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [orl_pkg::CharW-1:0]  char_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [orl_pkg::CodeW-1:0]  role_o,
  output logic [orl_pkg::CodeW-1:0]  error_code_o,
  output logic                       pair_done_o,
  output logic [orl_pkg::PairW-1:0]  pair_index_o,
  output logic                       string_done_o
);
  import orl_pkg::*;

  logic             in_valid_q;
  logic [CharW-1:0] char_q;
  logic             out_valid_q;
  result_t          result_q;
  result_t          result_d;
  state_t           state_q;
  state_t           state_d;
  logic             adv_out;
  logic             adv_in;

  assign adv_out    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv_out;
  assign adv_in     = in_valid_i && !in_stall_o;

  orl_step u_step (
    .state_i  (state_q),
    .char_i   (char_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (adv_in) begin
        in_valid_q <= 1'b1;
      end else if (adv_out) begin
        in_valid_q <= 1'b0;
      end
      if (adv_out) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in) begin
      char_q <= char_in_i;
    end
    if (adv_out) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign role_o        = result_q.role;
  assign error_code_o  = result_q.err;
  assign pair_done_o   = result_q.pair_done;
  assign pair_index_o  = result_q.pair_index;
  assign string_done_o = result_q.string_done;

`ifndef NO_ASSERTIONS
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_out && (char_q == ChNul)) |=>
      ((state_q.phase == PH_CLASS_START) && (state_q.err == ER_NONE)
       && (state_q.pair_cnt == '0) && !state_q.esc))
    else $error("state not rearmed after terminating byte");

  a_err_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.err != ER_NONE) |-> (state_q.phase == PH_ERROR))
    else $error("error latched outside error phase");

  a_done_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pair_done_o) |->
      ((role_o == RL_QUOTE) || (role_o == RL_COMMA) || (role_o == RL_IGNORED)))
    else $error("pair completed on unexpected role");

  a_end_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && string_done_o) |-> (role_o == RL_IGNORED))
    else $error("terminating byte with a non-ignored role");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while pipeline can advance");
`endif

endmodule
